// ===== rtl/fixed_point_radix2_fft_defines.svh =====
// Assertion helpers for the FFT core.
`ifndef FIXED_POINT_RADIX2_FFT_DEFINES_SVH
`define FIXED_POINT_RADIX2_FFT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define FXFFT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define FXFFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fxfft_pkg.sv =====
package fxfft_pkg;

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    q15_t re;
    q15_t im;
  } cplx_t;

  localparam int BIN_INDEX_W = 6;

  // 2*pi in Q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Taylor series denominators (2n)*(2n+1) for the sine terms
  localparam int SERIES_TERMS = 12;
  localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam logic [15:0] SWAP_1 = 16'h5555;
  localparam logic [15:0] SWAP_2 = 16'h3333;
  localparam logic [15:0] SWAP_4 = 16'h0F0F;
  localparam logic [15:0] SWAP_8 = 16'h00FF;

  function automatic logic [15:0] bit_rev16(input logic [15:0] v);
    logic [15:0] r;
    r = v;
    r = ((r >> 1) & SWAP_1) | ((r & SWAP_1) << 1);
    r = ((r >> 2) & SWAP_2) | ((r & SWAP_2) << 2);
    r = ((r >> 4) & SWAP_4) | ((r & SWAP_4) << 4);
    r = ((r >> 8) & SWAP_8) | ((r & SWAP_8) << 8);
    return r;
  endfunction

endpackage

// ===== rtl/fxfft_sample_if.sv =====
interface fxfft_sample_if;
  import fxfft_pkg::*;

  logic valid;
  logic ready;
  q15_t sample_re;
  q15_t sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

// ===== rtl/fxfft_bin_if.sv =====
interface fxfft_bin_if;
  import fxfft_pkg::*;

  logic valid;
  logic ready;
  q15_t bin_re;
  q15_t bin_im;
  logic [BIN_INDEX_W-1:0] bin_index;
  logic last_bin;

  modport source (output valid, output bin_re, output bin_im, output bin_index,
                  output last_bin, input ready);
  modport sink (input valid, input bin_re, input bin_im, input bin_index,
                input last_bin, output ready);
endinterface

// ===== rtl/fxfft_ram.sv =====
module fxfft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fixed_point_radix2_fft.sv =====
// Load: one sample per cycle while the source is valid, written to bit-reversed addresses.
// Transform: one butterfly per cycle over two banks split by address parity, except that
// the first butterfly of each stage waits for the previous stage to drain from the pipeline.
// Unload: one bin per cycle while the sink is ready, starting once the transform has drained.
// Reset clears control state only; sample memory contents stay undefined until loaded.
`include "fixed_point_radix2_fft_defines.svh"

module fixed_point_radix2_fft #(
  parameter int POINTS      = 64,
  parameter int LOG2_POINTS = 6
) (
  input logic          clk,
  input logic          rst_n,
  fxfft_sample_if.sink in_smp,
  fxfft_bin_if.source  out_bin
);
  import fxfft_pkg::*;

  localparam int AW = LOG2_POINTS;
  localparam int RW = LOG2_POINTS - 1;
  localparam int SW = (LOG2_POINTS > 1) ? $clog2(LOG2_POINTS) : 1;
  localparam int QN = POINTS / 4 + 1;

  localparam logic [RW-1:0] QUARTER  = RW'(POINTS / 4);
  localparam logic [RW-1:0] BF_LAST  = RW'(POINTS / 2 - 1);
  localparam logic [SW-1:0] STG_LAST = SW'(LOG2_POINTS - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(POINTS - 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_FFT    = 2'd1;
  localparam logic [1:0] ST_UNLOAD = 2'd2;

  // round(32768*sin(2*pi*q/POINTS)) for the first quarter, +1.0 saturated
  function automatic logic [15:0] sine_q(input int unsigned q);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    int                 n;
    x    = (TWO_PI_Q30 * 64'(q) + 64'(POINTS / 2)) / POINTS;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 0; n < SERIES_TERMS; n++) begin
      term = ((term * x2 + (64'd1 << 29)) >> 30) / SERIES_DIV[n];
      if (n % 2 == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return r[15:0];
  endfunction

  q15_t qtab [QN];

  for (genvar g = 0; g < QN; g++) begin : g_qtab
    localparam logic [15:0] QV = sine_q(g);
    assign qtab[g] = QV;
  end

  // control state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;
  logic [SW-1:0] stage_r, stage_nxt;
  logic [RW-1:0] bf_r, bf_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic [AW-1:0] u_r, u_nxt;

  // butterfly pipeline
  logic          v1_r, v2_r;
  logic [AW-1:0] ia1_r, ja1_r, ia2_r, ja2_r;
  q15_t          wr1_r, wi1_r;
  q15_t          prr2_r, pii2_r, pri2_r, pir2_r;
  q15_t          qre2_r, qim2_r;

  // unload path
  logic          pend_r, pbank_r;
  logic [AW-1:0] pidx_r;
  logic          out_valid_r, out_valid_nxt;
  logic          skid_v_r, skid_v_nxt;
  cplx_t         out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;
  logic [AW-1:0] out_idx_r, out_idx_nxt, skid_idx_r, skid_idx_nxt;

  // memory ports
  logic          we0_c, we1_c;
  logic [RW-1:0] waddr0_c, waddr1_c, raddr0_c, raddr1_c;
  cplx_t         wdata0_c, wdata1_c;
  logic [31:0]   rdata0, rdata1;

  fxfft_ram #(.WIDTH(32), .DEPTH(POINTS / 2)) u_bank0 (
    .clk   (clk),
    .we    (we0_c),
    .waddr (waddr0_c),
    .wdata (wdata0_c),
    .raddr (raddr0_c),
    .rdata (rdata0)
  );

  fxfft_ram #(.WIDTH(32), .DEPTH(POINTS / 2)) u_bank1 (
    .clk   (clk),
    .we    (we1_c),
    .waddr (waddr1_c),
    .wdata (wdata1_c),
    .raddr (raddr1_c),
    .rdata (rdata1)
  );

  // ---------------- load ----------------
  logic          ld_xfer;
  logic [AW-1:0] ld_addr_c;
  logic          ld_par_c;

  assign in_smp.ready = (state_r == ST_LOAD);
  assign ld_xfer      = in_smp.valid && in_smp.ready;
  assign ld_addr_c    = AW'(bit_rev16(16'(load_cnt_r)) >> (16 - LOG2_POINTS));
  assign ld_par_c     = ^ld_addr_c;

  // ---------------- butterfly issue ----------------
  logic          pipe_busy, bf_issue;
  logic [RW-1:0] lo_mask_c, m_c, tw_c, cidx_c, sidx_c;
  logic [SW-1:0] tw_sh_c;
  logic [AW-1:0] ia_c, ja_c;
  logic          tw_le_c, par_i_c;
  q15_t          cmag_c, smag_c, cos_c, nsin_c, wr_c, wi_c;

  assign pipe_busy = v1_r || v2_r;
  // first butterfly of a stage waits for the previous stage to drain
  assign bf_issue  = (state_r == ST_FFT) && !iss_done_r && ((bf_r != '0) || !pipe_busy);

  assign lo_mask_c = ~({RW{1'b1}} << stage_r);
  assign m_c       = bf_r & lo_mask_c;
  assign ia_c      = {bf_r & ~lo_mask_c, 1'b0} | {1'b0, m_c};
  assign ja_c      = ia_c | (AW'(1) << stage_r);
  assign par_i_c   = ^ia_c;
  assign tw_sh_c   = STG_LAST - stage_r;
  assign tw_c      = m_c << tw_sh_c;

  assign tw_le_c = (tw_c <= QUARTER);
  assign cidx_c  = tw_le_c ? (QUARTER - tw_c) : (tw_c - QUARTER);
  assign sidx_c  = tw_le_c ? tw_c : (RW'(0) - tw_c);
  assign cmag_c  = qtab[cidx_c];
  assign smag_c  = qtab[sidx_c];
  assign cos_c   = tw_le_c ? cmag_c : -cmag_c;
  assign nsin_c  = -smag_c;
  assign wr_c    = cos_c >>> 1;
  assign wi_c    = nsin_c >>> 1;

  always_comb begin
    if (state_r == ST_UNLOAD) begin
      raddr0_c = u_r[AW-1:1];
      raddr1_c = u_r[AW-1:1];
    end else begin
      raddr0_c = par_i_c ? ja_c[AW-1:1] : ia_c[AW-1:1];
      raddr1_c = par_i_c ? ia_c[AW-1:1] : ja_c[AW-1:1];
    end
  end

  // ---------------- stage 1: multiply ----------------
  cplx_t              a_c, b_c;
  q15_t               a_re_c, a_im_c, b_re_c, b_im_c;
  logic signed [31:0] prr_c, pii_c, pri_c, pir_c;

  assign a_c    = (^ia1_r) ? rdata1 : rdata0;
  assign b_c    = (^ia1_r) ? rdata0 : rdata1;
  assign a_re_c = a_c.re;
  assign a_im_c = a_c.im;
  assign b_re_c = b_c.re;
  assign b_im_c = b_c.im;
  assign prr_c  = wr1_r * b_re_c;
  assign pii_c  = wi1_r * b_im_c;
  assign pri_c  = wr1_r * b_im_c;
  assign pir_c  = wi1_r * b_re_c;

  // ---------------- stage 2: add and write back ----------------
  q15_t  tr_c, ti_c;
  cplx_t oi_c, oj_c;

  assign tr_c    = prr2_r - pii2_r;
  assign ti_c    = pri2_r + pir2_r;
  assign oi_c.re = qre2_r + tr_c;
  assign oi_c.im = qim2_r + ti_c;
  assign oj_c.re = qre2_r - tr_c;
  assign oj_c.im = qim2_r - ti_c;

  always_comb begin
    we0_c = ld_xfer && !ld_par_c;
    we1_c = ld_xfer && ld_par_c;
    waddr0_c = ld_addr_c[AW-1:1];
    waddr1_c = ld_addr_c[AW-1:1];
    wdata0_c = {in_smp.sample_re, in_smp.sample_im};
    wdata1_c = {in_smp.sample_re, in_smp.sample_im};
    if (v2_r) begin
      we0_c = 1'b1;
      we1_c = 1'b1;
      if (^ia2_r) begin
        waddr0_c = ja2_r[AW-1:1];
        wdata0_c = oj_c;
        waddr1_c = ia2_r[AW-1:1];
        wdata1_c = oi_c;
      end else begin
        waddr0_c = ia2_r[AW-1:1];
        wdata0_c = oi_c;
        waddr1_c = ja2_r[AW-1:1];
        wdata1_c = oj_c;
      end
    end
  end

  // ---------------- unload ----------------
  logic  out_take, out_free, rd_issue;
  logic [1:0] occ_c;
  cplx_t pd_c;

  assign out_take = out_valid_r && out_bin.ready;
  assign out_free = !out_valid_r || out_take;
  assign occ_c    = {1'b0, out_valid_r} + {1'b0, skid_v_r} + {1'b0, pend_r};
  assign rd_issue = (state_r == ST_UNLOAD) && ((occ_c < 2'd2) || ((occ_c == 2'd2) && out_take));
  assign pd_c     = pbank_r ? rdata1 : rdata0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_d_nxt     = out_d_r;
    out_idx_nxt   = out_idx_r;
    skid_v_nxt    = skid_v_r;
    skid_d_nxt    = skid_d_r;
    skid_idx_nxt  = skid_idx_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_valid_nxt = 1'b1;
        out_d_nxt     = skid_d_r;
        out_idx_nxt   = skid_idx_r;
        skid_v_nxt    = pend_r;
        skid_d_nxt    = pd_c;
        skid_idx_nxt  = pidx_r;
      end else begin
        out_valid_nxt = pend_r;
        out_d_nxt     = pd_c;
        out_idx_nxt   = pidx_r;
      end
    end else if (pend_r) begin
      // hold the arriving bin behind the stalled one
      skid_v_nxt   = 1'b1;
      skid_d_nxt   = pd_c;
      skid_idx_nxt = pidx_r;
    end
  end

  assign out_bin.valid     = out_valid_r;
  assign out_bin.bin_re    = out_d_r.re;
  assign out_bin.bin_im    = out_d_r.im;
  assign out_bin.bin_index = BIN_INDEX_W'(out_idx_r);
  assign out_bin.last_bin  = (out_idx_r == IDX_LAST);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    stage_nxt    = stage_r;
    bf_nxt       = bf_r;
    iss_done_nxt = iss_done_r;
    u_nxt        = u_r;
    unique case (state_r)
      ST_LOAD: begin
        if (ld_xfer) begin
          load_cnt_nxt = load_cnt_r + 1'b1;
          if (load_cnt_r == IDX_LAST) begin
            state_nxt    = ST_FFT;
            stage_nxt    = '0;
            bf_nxt       = '0;
            iss_done_nxt = 1'b0;
          end
        end
      end
      ST_FFT: begin
        if (bf_issue) begin
          if (bf_r == BF_LAST) begin
            bf_nxt = '0;
            if (stage_r == STG_LAST) begin
              iss_done_nxt = 1'b1;
            end else begin
              stage_nxt = stage_r + 1'b1;
            end
          end else begin
            bf_nxt = bf_r + 1'b1;
          end
        end
        if (iss_done_r && !pipe_busy) begin
          state_nxt = ST_UNLOAD;
          u_nxt     = '0;
        end
      end
      ST_UNLOAD: begin
        if (rd_issue) begin
          if (u_r == IDX_LAST) begin
            state_nxt = ST_LOAD;
          end else begin
            u_nxt = u_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      stage_r     <= '0;
      bf_r        <= '0;
      iss_done_r  <= 1'b0;
      u_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stage_r     <= stage_nxt;
      bf_r        <= bf_nxt;
      iss_done_r  <= iss_done_nxt;
      u_r         <= u_nxt;
      v1_r        <= bf_issue;
      v2_r        <= v1_r;
      pend_r      <= rd_issue;
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia1_r      <= ia_c;
    ja1_r      <= ja_c;
    wr1_r      <= wr_c;
    wi1_r      <= wi_c;
    ia2_r      <= ia1_r;
    ja2_r      <= ja1_r;
    prr2_r     <= prr_c[30:15];
    pii2_r     <= pii_c[30:15];
    pri2_r     <= pri_c[30:15];
    pir2_r     <= pir_c[30:15];
    qre2_r     <= a_re_c >>> 1;
    qim2_r     <= a_im_c >>> 1;
    pidx_r     <= u_r;
    pbank_r    <= ^u_r;
    out_d_r    <= out_d_nxt;
    out_idx_r  <= out_idx_nxt;
    skid_d_r   <= skid_d_nxt;
    skid_idx_r <= skid_idx_nxt;
  end

  `FXFFT_ASSERT_ALWAYS(a_bank_split, !v2_r || ((^ia2_r) != (^ja2_r)),
                       "butterfly pair in one bank")
  `FXFFT_ASSERT_ALWAYS(a_unload_cap, !(out_valid_r && skid_v_r && pend_r),
                       "unload over capacity")
  `FXFFT_ASSERT_ALWAYS(a_no_wr_unload, (state_r != ST_UNLOAD) || !(we0_c || we1_c),
                       "write in unload")
  `FXFFT_ASSERT_NEXT(a_load_done, ld_xfer && (load_cnt_r == IDX_LAST),
                     (state_r == ST_FFT) && (bf_r == '0) && (stage_r == '0),
                     "transform not started")

endmodule

// ===== test/tb_fixed_point_radix2_fft.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_radix2_fft;
  import fxfft_pkg::*;

  localparam int NPTS = 64;
  localparam int LOG2N = 6;
  localparam int FULL_BLOCKS = 4;
  localparam int TAIL_SAMPLES = 14;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    q15_t re;
    q15_t im;
    logic [BIN_INDEX_W-1:0] idx;
    logic last;
  } bin_t;

  logic clk = 1'b0;
  logic rst_n;

  fxfft_sample_if smp_if();
  fxfft_bin_if bin_if();

  fixed_point_radix2_fft #(
    .POINTS(NPTS),
    .LOG2_POINTS(LOG2N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_smp(smp_if),
    .out_bin(bin_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cplx_t samples_pending[$];
  bin_t bins_due[$];
  int sine_tbl[NPTS];
  q15_t frame_re[NPTS];
  q15_t frame_im[NPTS];
  int frame_fill = 0;

  int smp_count = 0;
  int bin_count = 0;
  int frame_count = 0;
  int err_cnt = 0;
  int stall_cycles = 0;
  logic smp_taken;

  // round(32768*sin(2*pi*q/NPTS)) for the first quarter, by a Taylor series in Q30
  function automatic int quarter_sine(int unsigned q);
    longint unsigned x, x2, term;
    longint acc, r;
    int n;
    x = (TWO_PI_Q30 * 64'(q) + 64'(NPTS / 2)) / 64'(NPTS);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 12; n++) begin
      term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (acc + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  function automatic void build_sine_tbl();
    int q, i;
    q = NPTS / 4;
    for (i = 0; i < NPTS; i++) begin
      if (i <= q) sine_tbl[i] = quarter_sine(i);
      else if (i <= 2 * q) sine_tbl[i] = quarter_sine(2 * q - i);
      else if (i <= 3 * q) sine_tbl[i] = -quarter_sine(i - 2 * q);
      else sine_tbl[i] = -quarter_sine(4 * q - i);
    end
  endfunction

  function automatic int rev_index(int m);
    int r, b;
    r = 0;
    for (b = 0; b < LOG2N; b++)
      if (m & (1 << b)) r = r | (1 << (LOG2N - 1 - b));
    return r;
  endfunction

  // Q15 product, floor on the shift, wrap to 16 bits
  function automatic q15_t qmul(int a, q15_t b);
    int p;
    p = a * int'(b);
    return q15_t'(p >>> 15);
  endfunction

  // Scaled in-place DIT transform of the collected frame; queue all bins
  function automatic void fft_predict();
    q15_t tre[NPTS];
    q15_t tim[NPTS];
    q15_t tr, ti;
    int span, stride, k, m, i, j, tw, wr, wi, qr, qi;
    bin_t b;
    for (m = 0; m < NPTS; m++) begin
      tre[rev_index(m)] = frame_re[m];
      tim[rev_index(m)] = frame_im[m];
    end
    k = LOG2N - 1;
    for (span = 1; span < NPTS; span = stride) begin
      stride = span * 2;
      for (m = 0; m < span; m++) begin
        tw = (m << k) & (NPTS - 1);
        wr = sine_tbl[(tw + NPTS / 4) & (NPTS - 1)] >>> 1;
        wi = (-sine_tbl[tw]) >>> 1;
        for (i = m; i < NPTS; i += stride) begin
          j = (i + span) & (NPTS - 1);
          tr = q15_t'(int'(qmul(wr, tre[j])) - int'(qmul(wi, tim[j])));
          ti = q15_t'(int'(qmul(wr, tim[j])) + int'(qmul(wi, tre[j])));
          qr = int'(tre[i]) >>> 1;
          qi = int'(tim[i]) >>> 1;
          tre[j] = q15_t'(qr - int'(tr));
          tim[j] = q15_t'(qi - int'(ti));
          tre[i] = q15_t'(qr + int'(tr));
          tim[i] = q15_t'(qi + int'(ti));
        end
      end
      if (k > 0) k--;
    end
    for (m = 0; m < NPTS; m++) begin
      b.re = tre[m];
      b.im = tim[m];
      b.idx = BIN_INDEX_W'(m);
      b.last = (m == NPTS - 1);
      bins_due.push_back(b);
    end
  endfunction

  function automatic void load_sample(q15_t re, q15_t im);
    frame_re[frame_fill] = re;
    frame_im[frame_fill] = im;
    frame_fill++;
    if (frame_fill == NPTS) begin
      frame_fill = 0;
      frame_count++;
      fft_predict();
    end
  endfunction

  function automatic void check_bin();
    bin_t exp_b;
    if (bins_due.size() == 0) begin
      err_cnt++;
      $display("%0t: unexpected bin idx %0d re %0d im %0d last %0d", $time,
               bin_if.bin_index, bin_if.bin_re, bin_if.bin_im, bin_if.last_bin);
      return;
    end
    exp_b = bins_due.pop_front();
    bin_count++;
    if (bin_if.bin_re !== exp_b.re || bin_if.bin_im !== exp_b.im ||
        bin_if.bin_index !== exp_b.idx || bin_if.last_bin !== exp_b.last) begin
      err_cnt++;
      $display("%0t: bin expected re %0d im %0d idx %0d last %0d,", $time,
               exp_b.re, exp_b.im, exp_b.idx, exp_b.last);
      $display("    got re %0d im %0d idx %0d last %0d",
               bin_if.bin_re, bin_if.bin_im, bin_if.bin_index, bin_if.last_bin);
    end
  endfunction

  function automatic q15_t rand_q15();
    return q15_t'($urandom_range(0, 65535));
  endfunction

  // Pick extremes often, otherwise any value
  function automatic q15_t edgy_q15();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return q15_t'(16'h8000);
    if (pick == 1) return q15_t'(16'h7FFF);
    return rand_q15();
  endfunction

  // Monitor: predict on sample transfers, check on bin transfers, watch for stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_taken <= 1'b0;
    end else begin
      smp_taken <= smp_if.valid && smp_if.ready;
      if (smp_if.valid && smp_if.ready) begin
        load_sample(smp_if.sample_re, smp_if.sample_im);
        smp_count++;
      end
      if (bin_if.valid && bin_if.ready)
        check_bin();
      if ((smp_if.valid && smp_if.ready) || (bin_if.valid && bin_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // Driver: idle mix changes as the stream advances
  always @(negedge clk) begin : drive_proc
    cplx_t nxt;
    int send_idle, recv_idle;
    if (smp_count < 90) begin
      send_idle = 16;
      recv_idle = 62;
    end else if (smp_count < 180) begin
      send_idle = 62;
      recv_idle = 16;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if (!rst_n) begin
      smp_if.valid <= 1'b0;
      bin_if.ready <= 1'b0;
    end else begin
      if (!smp_if.valid || smp_taken) begin
        if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          nxt = samples_pending.pop_front();
          smp_if.valid <= 1'b1;
          smp_if.sample_re <= nxt.re;
          smp_if.sample_im <= nxt.im;
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
      bin_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin : stim_proc
    int dir_re[25] = '{32767, -32768, 32767, -32768, 0, -1, 1, -1, 0, 16384, -16384,
                       21845, -21846, 13107, -13108, 3855, -3856, 255, -256, 32767,
                       -32768, 1, -32768, 32767, 0};
    int dir_im[25] = '{32767, -32768, -32768, 32767, 0, -1, 1, 0, -1, -16384, 16384,
                       -21846, 21845, -13108, 13107, -3856, 3855, -256, 255, 0,
                       0, -32768, 1, -1, 32767};
    cplx_t s;
    int n, f, sh, total;
    smp_if.valid = 1'b0;
    smp_if.sample_re = '0;
    smp_if.sample_im = '0;
    bin_if.ready = 1'b0;
    rst_n = 1'b0;
    build_sine_tbl();

    // Frame 0: field extremes and bit patterns, completed with random samples
    for (n = 0; n < NPTS; n++) begin
      if (n < 25) begin
        s.re = q15_t'(dir_re[n]);
        s.im = q15_t'(dir_im[n]);
      end else begin
        s.re = rand_q15();
        s.im = rand_q15();
      end
      samples_pending.push_back(s);
    end
    // Frame 1: full-range noise
    for (n = 0; n < NPTS; n++) begin
      s.re = rand_q15();
      s.im = rand_q15();
      samples_pending.push_back(s);
    end
    // Frame 2: complex tone at a random bin and level, with a little noise
    f = $urandom_range(0, NPTS - 1);
    sh = $urandom_range(0, 3);
    for (n = 0; n < NPTS; n++) begin
      s.re = q15_t'((sine_tbl[(f * n + NPTS / 4) & (NPTS - 1)] >>> sh) +
                    $urandom_range(0, 7) - 4);
      s.im = q15_t'((sine_tbl[(f * n) & (NPTS - 1)] >>> sh) + $urandom_range(0, 7) - 4);
      samples_pending.push_back(s);
    end
    // Frame 3: rail values mixed with noise to force wraps
    for (n = 0; n < NPTS; n++) begin
      s.re = edgy_q15();
      s.im = edgy_q15();
      samples_pending.push_back(s);
    end
    // Partial frame left in the block at the end
    for (n = 0; n < TAIL_SAMPLES; n++) begin
      s.re = rand_q15();
      s.im = rand_q15();
      samples_pending.push_back(s);
    end
    total = samples_pending.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (smp_count < total) @(posedge clk);
    while (bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d samples (%0d full frames plus a partial one), checked %0d bins",
             smp_count, frame_count, bin_count);
    $display("Frames covered rail values, bit patterns, noise and a tone at bin %0d", f);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
